>>> design/smse_pkg.sv
// Shared widths, operation and status codes, and controller-to-datapath types for the engine.
package smse_pkg;

  localparam int OP_W   = 2;
  localparam int POS_W  = 11;
  localparam int VAL_W  = 16;
  localparam int SUM_W  = 26;
  localparam int STAT_W = 2;
  localparam int LEN_W  = 11;

  // Limits of the 26-bit signed result.
  localparam logic signed [31:0] SUM_HI = 32'sd33554431;
  localparam logic signed [31:0] SUM_LO = -32'sd33554432;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT  = 2'd0,
    OP_DELETE  = 2'd1,
    OP_REPLACE = 2'd2,
    OP_QUERY   = 2'd3
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2
  } stat_t;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_CHECK,
    CMD_WALK,
    CMD_FINISH,
    CMD_RESULT
  } cmd_t;

  typedef struct packed {
    logic err;
    logic need_walk;
    logic walk_last;
  } dp_status_t;

endpackage

>>> design/smse_ctrl.sv
// Controller state machine that sequences check, walk, commit and result hand-off.
module smse_ctrl import smse_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t flags,
  output cmd_t       cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_WALK,
    S_DRAIN,
    S_FINISH,
    S_RESP
  } state_t;

  state_t state;
  logic   slot_free;

  assign in_ready  = (state == S_IDLE);
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    case (state)
      S_IDLE:   cmd = in_valid ? CMD_LOAD : CMD_NONE;
      S_CHECK:  cmd = CMD_CHECK;
      S_WALK:   cmd = CMD_WALK;
      S_FINISH: cmd = CMD_FINISH;
      S_RESP:   cmd = slot_free ? CMD_RESULT : CMD_NONE;
      default:  cmd = CMD_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) state <= S_CHECK;
        end
        S_CHECK: begin
          if (flags.err) state <= S_RESP;
          else if (flags.need_walk) state <= S_WALK;
          else state <= S_FINISH;
        end
        S_WALK: begin
          if (flags.walk_last) state <= S_DRAIN;
        end
        S_DRAIN: begin
          state <= S_FINISH;
        end
        S_FINISH: begin
          state <= S_RESP;
        end
        S_RESP: begin
          if (slot_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A rejected operation must skip the walk and the commit entirely.
  a_err_skips_commit: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHECK && flags.err) |=> (state == S_RESP))
    else $error("rejected operation did not go straight to the result");

endmodule

>>> design/smse_dp.sv
// Datapath: sequence memory, entry count, range checks, shift walker and Kadane scanner.
module smse_dp import smse_pkg::*; #(
  parameter int CAPACITY = 1024
) (
  input  logic                    clk,
  input  logic                    rst,
  input  cmd_t                    cmd,
  output dp_status_t              flags,
  input  logic [OP_W-1:0]         operation,
  input  logic [POS_W-1:0]        position,
  input  logic [POS_W-1:0]        end_position,
  input  logic signed [VAL_W-1:0] value,
  output logic signed [SUM_W-1:0] max_sum,
  output logic [STAT_W-1:0]       status,
  output logic [LEN_W-1:0]        length
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = ((CW > POS_W) ? CW : POS_W) + 1;
  localparam int SW = ((AW + 17) > 27) ? (AW + 17) : 27;
  localparam logic signed [SW-1:0] SAT_HI = SW'(SUM_HI);
  localparam logic signed [SW-1:0] SAT_LO = SW'(SUM_LO);

  logic signed [VAL_W-1:0] mem [CAPACITY];

  op_t                     op_r;
  logic [POS_W-1:0]        pos_r;
  logic [POS_W-1:0]        end_r;
  logic signed [VAL_W-1:0] val_r;
  stat_t                   st_r;
  stat_t                   st_chk;
  logic [CW-1:0]           count;
  logic [AW-1:0]           idx;
  logic [AW-1:0]           stop;
  logic                    up;
  logic [AW-1:0]           rd_addr_q;
  logic                    rd_valid;
  logic signed [VAL_W-1:0] rd_data;
  logic signed [SW-1:0]    cur;
  logic signed [SW-1:0]    best;
  logic                    first;

  logic [EW-1:0]           p_e;
  logic [EW-1:0]           b_e;
  logic [EW-1:0]           c_e;
  logic [EW-1:0]           p_m1;
  logic [EW-1:0]           b_m1;
  logic [EW-1:0]           c_m1;
  logic [AW-1:0]           at;
  logic                    need_walk;

  logic                    wr_en;
  logic [AW-1:0]           wr_addr;
  logic signed [VAL_W-1:0] wr_data;

  logic signed [SW-1:0]    v_ext;
  logic signed [SW-1:0]    cur_base;
  logic signed [SW-1:0]    cur_new;
  logic signed [SW-1:0]    best_new;
  logic signed [SW-1:0]    best_sat;

  assign p_e  = EW'(pos_r);
  assign b_e  = EW'(end_r);
  assign c_e  = EW'(count);
  assign p_m1 = p_e - EW'(1);
  assign b_m1 = b_e - EW'(1);
  assign c_m1 = c_e - EW'(1);
  assign at   = p_m1[AW-1:0];

  // Range checks; a full store is reported ahead of a bad insert position.
  always_comb begin
    st_chk    = ST_OK;
    need_walk = 1'b0;
    case (op_r)
      OP_INSERT: begin
        if (c_e == EW'(CAPACITY)) st_chk = ST_FULL;
        else if (p_e == '0 || p_e > c_e + EW'(1)) st_chk = ST_INVALID;
        need_walk = (p_e != c_e + EW'(1));
      end
      OP_DELETE: begin
        if (p_e == '0 || p_e > c_e) st_chk = ST_INVALID;
        need_walk = (p_e != c_e);
      end
      OP_REPLACE: begin
        if (p_e == '0 || p_e > c_e) st_chk = ST_INVALID;
      end
      OP_QUERY: begin
        if (p_e == '0 || p_e > b_e || b_e > c_e) st_chk = ST_INVALID;
        need_walk = 1'b1;
      end
      default: begin
        st_chk = ST_INVALID;
      end
    endcase
  end

  assign flags.err       = (st_chk != ST_OK);
  assign flags.need_walk = need_walk;
  assign flags.walk_last = (idx == stop);

  // Shifted entries are written in the cycle after they are read; the new or
  // replaced value goes in at the commit step once the walk has drained.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = rd_addr_q;
    wr_data = rd_data;
    if (rd_valid && op_r == OP_INSERT) begin
      wr_en   = 1'b1;
      wr_addr = rd_addr_q + AW'(1);
    end else if (rd_valid && op_r == OP_DELETE) begin
      wr_en   = 1'b1;
      wr_addr = rd_addr_q - AW'(1);
    end else if (cmd == CMD_FINISH && (op_r == OP_INSERT || op_r == OP_REPLACE)) begin
      wr_en   = 1'b1;
      wr_addr = at;
      wr_data = val_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (cmd == CMD_WALK) rd_data <= mem[idx];
  end

  // Kadane step: the running sum restarts whenever its past part is negative.
  always_comb begin
    v_ext    = SW'(rd_data);
    cur_base = (first || cur < 0) ? '0 : cur;
    cur_new  = v_ext + cur_base;
    best_new = (first || cur_new > best) ? cur_new : best;
    if (best > SAT_HI) best_sat = SAT_HI;
    else if (best < SAT_LO) best_sat = SAT_LO;
    else best_sat = best;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      rd_valid <= 1'b0;
      st_r     <= ST_OK;
    end else begin
      rd_valid <= (cmd == CMD_WALK);
      case (cmd)
        CMD_LOAD: begin
          op_r  <= op_t'(operation);
          pos_r <= position;
          end_r <= end_position;
          val_r <= value;
        end
        CMD_CHECK: begin
          st_r  <= st_chk;
          first <= 1'b1;
          case (op_r)
            OP_INSERT: begin
              idx  <= c_m1[AW-1:0];
              stop <= at;
              up   <= 1'b0;
            end
            OP_DELETE: begin
              idx  <= at + AW'(1);
              stop <= c_m1[AW-1:0];
              up   <= 1'b1;
            end
            default: begin
              idx  <= at;
              stop <= b_m1[AW-1:0];
              up   <= 1'b1;
            end
          endcase
        end
        CMD_WALK: begin
          idx       <= up ? idx + AW'(1) : idx - AW'(1);
          rd_addr_q <= idx;
        end
        CMD_FINISH: begin
          if (op_r == OP_INSERT) count <= count + CW'(1);
          else if (op_r == OP_DELETE) count <= count - CW'(1);
        end
        CMD_RESULT: begin
          max_sum <= (op_r == OP_QUERY && st_r == ST_OK) ? best_sat[SUM_W-1:0] : '0;
          status  <= st_r;
          length  <= LEN_W'(count);
        end
        default: begin
        end
      endcase
      if (rd_valid && op_r == OP_QUERY) begin
        cur   <= cur_new;
        best  <= best_new;
        first <= 1'b0;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count beyond capacity");

  a_commit_after_drain: assert property (@(posedge clk) disable iff (rst)
    (cmd == CMD_FINISH) |-> !rd_valid)
    else $error("commit write collided with a shift write");

endmodule

>>> design/sequence_max_subarray_engine_core.sv
// Top level of the sequence maximum-subarray engine: controller, datapath and ports.
//
// The engine holds an ordered sequence of up to CAPACITY signed 16-bit values in
// one on-chip memory and takes one operation per input transaction: insert a
// value so that it lands at 1-based position p, delete position p, replace
// position p, or query the largest sum of any non-empty contiguous run between
// positions a and b. Every input transaction gives exactly one output
// transaction carrying the best sum (zero unless the operation is a successful
// query), a status code (ok, invalid position or range, or store full on
// insert) and the number of values held afterwards. A rejected operation leaves
// the sequence untouched. Work proceeds one operation at a time, moving or
// scanning one stored entry per clock through the memory's single read and
// single write port: an insert shifts the entries from p upwards (count-p+1
// entries), a delete shifts those above p (count-p entries), a query scans b-a+1
// entries, and a replace moves nothing. On top of that walk an operation passes
// through acceptance, checking, draining the read pipeline after a walk,
// committing unless rejected, and loading the result. A finished result sits
// in an output register, and the next transaction is accepted while it waits
// to be taken. The memory needs no clearing after reset: only entries below the
// count are ever read.
module sequence_max_subarray_engine_core import smse_pkg::*; #(
  parameter int CAPACITY = 1024
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [OP_W-1:0]         operation,
  input  logic [POS_W-1:0]        position,
  input  logic [POS_W-1:0]        end_position,
  input  logic signed [VAL_W-1:0] value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [SUM_W-1:0] max_sum,
  output logic [STAT_W-1:0]       status,
  output logic [LEN_W-1:0]        length
);

  cmd_t       cmd;
  dp_status_t flags;

  // The controller only sequences; all storage and arithmetic sit in the datapath.
  smse_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .flags     (flags),
    .cmd       (cmd)
  );

  smse_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .flags        (flags),
    .operation    (operation),
    .position     (position),
    .end_position (end_position),
    .value        (value),
    .max_sum      (max_sum),
    .status       (status),
    .length       (length)
  );

  // Only one operation is in flight, so acceptance closes straight after a transaction.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second transaction accepted while one is in progress");

  // A sum is reported only by a successful query.
  a_sum_only_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_OK) |-> (max_sum == '0))
    else $error("non-zero sum on a rejected operation");

endmodule

>>> dv/tb_top.sv
// Self-checking testbench for the sequence maximum-subarray engine core.
`timescale 1ns / 100ps

module tb_top;
  import smse_pkg::*;

  localparam int CAPACITY = 1024;
  // Length of the closing run of equal large values; long enough for long shifts.
  localparam int FILL_LEN = 64;
  // Far beyond the slowest legal run of this stimulus.
  localparam longint LIMIT_NS = 64'd10_000_000;

  // One operation as it is presented on the input channel.
  typedef struct packed {
    op_t                     op;
    logic [POS_W-1:0]        pos;
    logic [POS_W-1:0]        end_pos;
    logic signed [VAL_W-1:0] val;
  } seq_op_t;

  // What the engine must answer for one operation.
  typedef struct packed {
    logic signed [SUM_W-1:0] max_sum;
    logic [STAT_W-1:0]       status;
    logic [LEN_W-1:0]        length;
  } op_outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                    in_valid  = 1'b0;
  logic                    out_ready = 1'b0;
  logic                    in_ready;
  logic                    out_valid;
  logic signed [SUM_W-1:0] max_sum;
  logic [STAT_W-1:0]       status;
  logic [LEN_W-1:0]        length;
  seq_op_t                 cur_op    = '0;

  seq_op_t                 op_backlog[$];       // operations still to be sent
  op_outcome_t             awaited_outcomes[$]; // answers owed by the engine
  logic signed [VAL_W-1:0] held_values[$];      // predicted sequence contents
  int                      planned_len = 0;     // length as the stimulus plan sees it
  int                      mismatch_count = 0;
  int                      outcomes_seen = 0;

  logic in_taken  = 1'b0;
  logic out_taken = 1'b0;
  int   in_gap    = 0;
  int   out_hold  = 0;
  bit   in_calm   = 1'b0;
  bit   out_calm  = 1'b0;

  sequence_max_subarray_engine_core #(
    .CAPACITY(CAPACITY)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .operation   (cur_op.op),
    .position    (cur_op.pos),
    .end_position(cur_op.end_pos),
    .value       (cur_op.val),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .max_sum     (max_sum),
    .status      (status),
    .length      (length)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(string msg);
    mismatch_count++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // Applies one operation to the predicted sequence and returns the answer owed.
  // The best-run search is a Kadane scan held in 64 bits and then clamped.
  function automatic op_outcome_t apply_operation(seq_op_t it);
    op_outcome_t r;
    int          p;
    int          b;
    int          i;
    longint      run;
    longint      best;
    r.max_sum = '0;
    r.status  = ST_OK;
    p = int'(it.pos);
    b = int'(it.end_pos);
    case (it.op)
      OP_INSERT: begin
        if (held_values.size() >= CAPACITY) begin
          r.status = ST_FULL;
        end else if (p < 1 || p > held_values.size() + 1) begin
          r.status = ST_INVALID;
        end else begin
          held_values.insert(p - 1, it.val);
        end
      end
      OP_DELETE: begin
        if (p < 1 || p > held_values.size()) begin
          r.status = ST_INVALID;
        end else begin
          held_values.delete(p - 1);
        end
      end
      OP_REPLACE: begin
        if (p < 1 || p > held_values.size()) begin
          r.status = ST_INVALID;
        end else begin
          held_values[p - 1] = it.val;
        end
      end
      default: begin
        if (p < 1 || p > b || b > held_values.size()) begin
          r.status = ST_INVALID;
        end else begin
          run  = held_values[p - 1];
          best = run;
          for (i = p; i < b; i++) begin
            run = (run + held_values[i] > held_values[i]) ? run + held_values[i]
                                                          : held_values[i];
            if (run > best) best = run;
          end
          if (best > SUM_HI) best = longint'(SUM_HI);
          if (best < SUM_LO) best = longint'(SUM_LO);
          r.max_sum = best[SUM_W-1:0];
        end
      end
    endcase
    r.length = LEN_W'(held_values.size());
    return r;
  endfunction

  function automatic int draw_wait(bit calm);
    return calm ? 0 : int'($urandom_range(0, 19));
  endfunction

  // Queues one operation and keeps the planned length in step, so that later
  // random operations can be aimed inside or outside the sequence on purpose.
  function automatic void push_op(op_t op, int p, int b, int v);
    seq_op_t it;
    it.op      = op;
    it.pos     = p[POS_W-1:0];
    it.end_pos = b[POS_W-1:0];
    it.val     = v[VAL_W-1:0];
    if (op == OP_INSERT && planned_len < CAPACITY && p >= 1 && p <= planned_len + 1) begin
      planned_len++;
    end else if (op == OP_DELETE && p >= 1 && p <= planned_len) begin
      planned_len--;
    end
    op_backlog.push_back(it);
  endfunction

  function automatic int pick_value();
    case ($urandom_range(0, 7))
      0:       return -32768;
      1:       return 32767;
      2:       return int'($urandom_range(0, 16)) - 8;
      default: return int'($urandom & 32'hFFFF);
    endcase
  endfunction

  // A position just past, far past, or below the legal span 1..limit.
  function automatic int bad_position(int limit);
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return limit + 1;
      2:       return int'($urandom_range(limit + 1, 2047));
      default: return 2047;
    endcase
  endfunction

  // Mostly well-formed operations; the mix of inserts and deletes steers the
  // length towards target, and about one in seven is deliberately malformed.
  function automatic void add_random_op(int target);
    int  r;
    int  ins_w;
    int  del_w;
    int  a;
    int  b;
    bit  broken;
    ins_w  = (planned_len < target) ? 50 : (planned_len > target) ? 10 : 30;
    del_w  = (planned_len > target) ? 50 : (planned_len < target) ? 10 : 30;
    r      = $urandom_range(0, 99);
    broken = ($urandom_range(0, 99) < 15);
    if (r < ins_w) begin
      a = broken ? bad_position(planned_len + 1) : int'($urandom_range(1, planned_len + 1));
      push_op(OP_INSERT, a, $urandom, pick_value());
    end else if (r < ins_w + del_w) begin
      a = (broken || planned_len == 0) ? bad_position(planned_len)
                                       : int'($urandom_range(1, planned_len));
      push_op(OP_DELETE, a, $urandom, pick_value());
    end else if (r < ins_w + del_w + 15) begin
      a = (broken || planned_len == 0) ? bad_position(planned_len)
                                       : int'($urandom_range(1, planned_len));
      push_op(OP_REPLACE, a, $urandom, pick_value());
    end else begin
      if (!broken && planned_len > 0) begin
        a = $urandom_range(1, planned_len);
        b = $urandom_range(a, planned_len);
      end else begin
        case ($urandom_range(0, 2))
          0: begin
            a = 0;
            b = $urandom_range(0, planned_len);
          end
          1: begin
            if (planned_len >= 2) begin
              b = $urandom_range(1, planned_len - 1);
              a = $urandom_range(b + 1, planned_len);
            end else begin
              a = 1;
              b = 0;
            end
          end
          default: begin
            a = $urandom_range(1, planned_len + 1);
            b = $urandom_range(planned_len + 1, 2047);
          end
        endcase
      end
      push_op(OP_QUERY, a, b, pick_value());
    end
  endfunction

  // Input side: an accepted transaction is seen at the rising edge, and the
  // next one is offered at the following falling edge once its gap has passed.
  always @(posedge clk) begin
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        awaited_outcomes.push_back(apply_operation(cur_op));
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_gap = 0;
    end else if (!in_valid || in_taken) begin
      if (in_gap > 0) begin
        in_gap = in_gap - 1;
        in_valid <= 1'b0;
      end else if (op_backlog.size() != 0) begin
        cur_op   <= op_backlog.pop_front();
        in_valid <= 1'b1;
        if ($urandom_range(0, 39) == 0) in_calm = !in_calm;
        in_gap = draw_wait(in_calm);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output side: each result is checked against the oldest outstanding answer.
  always @(posedge clk) begin : outcome_check
    op_outcome_t want;
    op_outcome_t got;
    if (rst) begin
      out_taken <= 1'b0;
    end else begin
      out_taken <= out_valid && out_ready;
      if (out_valid && out_ready) begin
        got.max_sum = max_sum;
        got.status  = status;
        got.length  = length;
        if (awaited_outcomes.size() == 0) begin
          report_mismatch($sformatf("unexpected result: sum %0d status %0d length %0d",
                                    got.max_sum, got.status, got.length));
        end else begin
          want = awaited_outcomes.pop_front();
          if (got !== want) begin
            report_mismatch($sformatf(
              "result %0d: sum %0d/%0d status %0d/%0d length %0d/%0d (got/expected)",
              outcomes_seen, got.max_sum, want.max_sum, got.status, want.status,
              got.length, want.length));
          end
        end
        outcomes_seen++;
      end
    end
  end

  // The receiver holds off for a freshly drawn number of cycles after each result.
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      out_hold = 0;
    end else begin
      if (out_taken) begin
        if ($urandom_range(0, 39) == 0) out_calm = !out_calm;
        out_hold = draw_wait(out_calm);
      end
      if (out_hold > 0) begin
        out_hold = out_hold - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    int n;
    int target;

    // Directed opening: every rejection on an empty store, the value
    // extremes, inserts at the front, middle and back, and query corners.
    push_op(OP_QUERY,   1, 1, 0);
    push_op(OP_DELETE,  1, 0, 0);
    push_op(OP_REPLACE, 1, 0, 5);
    push_op(OP_INSERT,  0, 0, 7);
    push_op(OP_INSERT,  2, 0, 7);
    push_op(OP_INSERT,  2047, 2047, -1);
    push_op(OP_INSERT,  1, 0, -32768);
    push_op(OP_INSERT,  2, 0, 32767);
    push_op(OP_INSERT,  1, 0, -1);
    push_op(OP_INSERT,  2, 0, 0);
    push_op(OP_QUERY,   1, 4, 0);
    push_op(OP_QUERY,   1, 3, 0);
    push_op(OP_QUERY,   3, 3, 0);      // a lone negative entry
    push_op(OP_QUERY,   3, 2, 0);      // reversed range
    push_op(OP_QUERY,   0, 2, 0);
    push_op(OP_QUERY,   1, 5, 0);      // one past the end
    push_op(OP_QUERY,   1, 2047, 0);
    push_op(OP_REPLACE, 3, 0, 32767);
    push_op(OP_REPLACE, 5, 0, 1);
    push_op(OP_REPLACE, 0, 0, 1);
    push_op(OP_DELETE,  5, 0, 0);
    push_op(OP_DELETE,  0, 0, 0);
    push_op(OP_DELETE,  4, 0, 0);
    push_op(OP_DELETE,  1, 0, 0);
    push_op(OP_QUERY,   1, 2, 0);

    // Random traffic at small lengths, drifting between an empty store and
    // a few dozen entries.
    target = 0;
    for (n = 0; n < 420; n++) begin
      if (n % 60 == 0) begin
        target = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(4, 48));
      end
      add_random_op(target);
    end

    // Empty the store, then fill it with a run of the largest value so that
    // the closing operations shift and scan a long stretch.
    while (planned_len > 0) begin
      push_op(OP_DELETE, $urandom_range(1, planned_len), $urandom, pick_value());
    end
    while (planned_len < FILL_LEN) begin
      push_op(OP_INSERT, planned_len + 1, $urandom, 32767);
    end
    // Insert positions beyond, below and far beyond the legal span.
    push_op(OP_INSERT,  FILL_LEN + 2, 0, 0);
    push_op(OP_INSERT,  0, 0, 0);
    push_op(OP_INSERT,  2047, 0, 0);
    push_op(OP_QUERY,   1, FILL_LEN, 0);
    push_op(OP_QUERY,   FILL_LEN, FILL_LEN, 0);
    push_op(OP_REPLACE, FILL_LEN / 2, 0, -32768);
    push_op(OP_QUERY,   1, FILL_LEN, 0);
    push_op(OP_DELETE,  1, 0, 0);       // longest downward shift
    push_op(OP_INSERT,  1, 0, -32768);  // longest upward shift
    push_op(OP_DELETE,  FILL_LEN, 0, 0);
    push_op(OP_INSERT,  FILL_LEN, 0, -1);
    push_op(OP_REPLACE, FILL_LEN, 0, 12345);
    push_op(OP_QUERY,   2, FILL_LEN - 1, 0);
    push_op(OP_QUERY,   1, FILL_LEN + 1, 0);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (op_backlog.size() != 0 || in_valid) @(posedge clk);
    while (awaited_outcomes.size() != 0) @(posedge clk);
    // Leave room for any stray result that a finished walk might still emit.
    repeat (CAPACITY + 64) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #(LIMIT_NS);
    $display("== FAIL ==");
    $finish;
  end

endmodule

>>> sim.f
design/smse_pkg.sv
design/smse_ctrl.sv
design/smse_dp.sv
design/sequence_max_subarray_engine_core.sv
dv/tb_top.sv
